// File: hdl/ctt_pkg.sv
// shared types, widths and reset constants for the clock tempo tracker
// used by ctt_div and clock_tempo_tracker; no dependencies
package ctt_pkg;

  localparam int LEN_W       = 21;          // period and phase width
  localparam int CFG_W       = 20;          // widest config register
  localparam int PPQ_W       = 5;           // pulse count and pulse index width
  localparam int DIV_W       = 2 * LEN_W;   // divider dividend / quotient width
  localparam int SUM_W       = DIV_W + 1;   // quotient plus offset
  localparam int CNT_W       = $clog2(DIV_W + 1);
  localparam int CFG_IDX_W   = 3;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 48;
  localparam int TIME_BITS_DEF = 22;

  localparam logic [PPQ_W-1:0] IDX_NONE = 5'd31;
  localparam logic [PPQ_W-1:0] P_MIN    = 5'd4;
  localparam logic [PPQ_W-1:0] P_MAX    = 5'd24;

  // ceil(2^23/3): product shifted down by 23 is floor(x/3) for x below 2^21
  localparam int          LO_SHIFT = 23;
  localparam logic [21:0] LO_RECIP = 22'd2796203;

  localparam int unsigned PULSES_RST  = 4;
  localparam int unsigned LEN_MIN_RST = 8820;
  localparam int unsigned LEN_MAX_RST = 88200;
  localparam int unsigned DEF_LEN_RST = 22050;
  localparam int unsigned MARGIN_RST  = 4410;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PULSES      = 3'd0,
    REG_LEN_MIN     = 3'd1,
    REG_LEN_MAX     = 3'd2,
    REG_DEFAULT_LEN = 3'd3,
    REG_MARGIN      = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TB,
    ST_FRONT,
    ST_LO,
    ST_LEFT,
    ST_TO,
    ST_RUN,
    ST_SCALE,
    ST_TAIL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] nbits;   // dividend bits, left aligned in num
    logic [DIV_W-1:0] num;
    logic [LEN_W-1:0] den;
  } div_req_t;

  // upper bound first, then lower bound raised to at least 1
  function automatic logic [LEN_W-1:0] clamp_len(input logic [SUM_W-1:0] v,
                                                 input logic [LEN_W-1:0] lo,
                                                 input logic [LEN_W-1:0] hi);
    logic [SUM_W-1:0] t;
    logic [LEN_W-1:0] l;
    t = (v > SUM_W'(hi)) ? SUM_W'(hi) : v;
    l = (lo == '0) ? LEN_W'(1) : lo;
    if (t < SUM_W'(l)) begin
      t = SUM_W'(l);
    end
    return t[LEN_W-1:0];
  endfunction

endpackage

// File: hdl/ctt_div.sv
// restoring divider, one quotient bit per cycle, shared by every division
// depends on ctt_pkg for widths and the request struct
module ctt_div (
  input  logic                     clk,
  input  logic                     rst,
  input  ctt_pkg::div_req_t        req,
  output logic                     done,
  output logic [ctt_pkg::DIV_W-1:0] quot
);
  import ctt_pkg::*;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] acc;
  logic [LEN_W-1:0] den;
  logic [LEN_W-1:0] rem;
  logic [LEN_W:0]   trial;
  logic             ge;

  assign trial = {rem, acc[DIV_W-1]};
  assign ge    = (trial >= {1'b0, den});
  assign quot  = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.nbits;
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift into the low end as the dividend leaves the top
  always_ff @(posedge clk) begin
    if (req.start) begin
      acc <= req.num;
      den <= req.den;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? LEN_W'(trial - {1'b0, den}) : trial[LEN_W-1:0];
      acc <= {acc[DIV_W-2:0], ge};
    end
  end

endmodule

// File: hdl/clock_tempo_tracker.sv
// clock tempo tracker top level: sequencer, tempo state and stream ports
// depends on ctt_pkg and ctt_div (shared divider)
//
// usage
// - one slave transfer is one audio sample tick: s_tdata[0] flags a rising
//   edge of the external clock, s_tdata[1] a rising edge of its reset
// - one master transfer answers every tick with the state after that tick:
//   running flag, period length, phase count and phase-active flag
// - config writes go over cfg_valid/cfg_ready with cfg_index/cfg_data;
//   cfg_ready is always high, writes are meant for idle time only
// - every division goes through one shared restoring divider, one quotient
//   bit per cycle; that divider sets the tick time; the wide range lower
//   bound (length_min*2/3) comes from a reciprocal multiply instead
// - a tick with no counted clock pulse runs one 20 bit division (the
//   timeout base) between transfer and result; the next tick can
//   transfer in the cycle after the result is loaded
// - a clock pulse past the first of a period adds the ST_LO step and two
//   divisions of TIME_BITS+5 bits, and a length change while the phase
//   runs adds a 42 bit rescale
// - s_tready is high only between ticks; a finished result sits in the
//   output register, so the next tick is taken while it waits; if the
//   receiver still stalls when the next result is ready, the sequencer holds
// - rst clears the tempo state and restores the register reset values;
//   no clearing pass is needed
module clock_tempo_tracker #(
  parameter int TIME_BITS = ctt_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [0] clock_edge, [1] reset_edge, [7:2] zero
  input  logic [ctt_pkg::IN_DATA_W-1:0] s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [0] is_running, [21:1] period_length, [42:22] phase_count,
  // [43] phase_active, [47:44] zero
  output logic [ctt_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ctt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ctt_pkg::CFG_W-1:0]     cfg_data
);
  import ctt_pkg::*;

  localparam int MUL_W = TIME_BITS + PPQ_W;   // interval times pulse factor
  localparam int ALIGN = DIV_W - MUL_W;
  localparam longint unsigned TC_RAW = LEN_MAX_RST / PULSES_RST + MARGIN_RST;
  localparam longint unsigned T_MAX  = (64'd1 << TIME_BITS) - 64'd1;
  localparam logic [TIME_BITS-1:0] TC_INIT =
    TIME_BITS'((TC_RAW > T_MAX) ? T_MAX : TC_RAW);
  localparam logic [SUM_W-1:0] T_MAX_SUM = SUM_W'({TIME_BITS{1'b1}});

  // config registers
  logic [PPQ_W-1:0] pulses_per_period;
  logic [CFG_W-1:0] length_min;
  logic [CFG_W-1:0] length_max;
  logic [CFG_W-1:0] timeout_margin;

  // tempo state
  logic                 running_flag,   running_flag_next;
  logic [PPQ_W-1:0]     pulse_index,    pulse_index_next;
  logic [TIME_BITS-1:0] interval_count, interval_count_next;
  logic [TIME_BITS-1:0] timeout_count,  timeout_count_next;
  logic [LEN_W-1:0]     master_period,  master_period_next;
  logic [LEN_W-1:0]     phase_value,    phase_value_next;
  logic                 phase_on,       phase_on_next;

  // per-tick working registers
  state_t               state, state_next;
  logic                 in_clk, in_clk_next;
  logic                 in_rst, in_rst_next;
  logic [TIME_BITS-1:0] tb, tb_next;              // timeout after soft reset
  logic [LEN_W-1:0]     lo_wide, lo_wide_next;    // length_min*2/3
  logic [LEN_W-1:0]     pending, pending_next;    // next period length
  logic                 load_out;

  // divider
  div_req_t         div_req;
  logic             div_done;
  logic [DIV_W-1:0] div_quot;

  // derived values
  logic [PPQ_W-1:0]     p_eff;
  logic [LEN_W:0]       lm3;
  logic [LEN_W-1:0]     hi_wide;
  logic [LO_SHIFT+LEN_W-1:0] lo_prod;
  logic [SUM_W-1:0]     q_sum;
  logic [TIME_BITS-1:0] q_sat;
  logic [TIME_BITS-1:0] ic_inc;
  logic [LEN_W-1:0]     phase_cur;
  logic [MUL_W-1:0]     mul_left;
  logic [MUL_W-1:0]     mul_to;
  logic [DIV_W-1:0]     mul_scale;
  logic                 front_sr;
  logic [PPQ_W-1:0]     pi_base;
  logic [PPQ_W-1:0]     pi_adv;
  logic [LEN_W-1:0]     mp_norm;
  logic [LEN_W-1:0]     pend_norm;
  logic                 stop;
  logic                 po_t;
  logic [LEN_W-1:0]     pv_t;
  logic [LEN_W:0]       pv1;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  ctt_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quot (div_quot)
  );

  // config writes; the default length only matters at rst, where it is
  // back at its reset value, so it is not kept
  always_ff @(posedge clk) begin
    if (rst) begin
      pulses_per_period <= PPQ_W'(PULSES_RST);
      length_min        <= CFG_W'(LEN_MIN_RST);
      length_max        <= CFG_W'(LEN_MAX_RST);
      timeout_margin    <= CFG_W'(MARGIN_RST);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PULSES:      pulses_per_period <= cfg_data[PPQ_W-1:0];
        REG_LEN_MIN:     length_min        <= cfg_data;
        REG_LEN_MAX:     length_max        <= cfg_data;
        REG_DEFAULT_LEN: ;
        REG_MARGIN:      timeout_margin    <= cfg_data;
        default:         ;
      endcase
    end
  end

  // pulse count saturated to its legal range
  assign p_eff = (pulses_per_period < P_MIN) ? P_MIN :
                 (pulses_per_period > P_MAX) ? P_MAX : pulses_per_period;

  // wide range upper bound, length_max*3/2
  assign lm3     = ({2'b00, length_max} << 1) + {2'b00, length_max};
  assign hi_wide = lm3[LEN_W:1];

  // wide range lower bound, (length_min*2) times the reciprocal of 3
  assign lo_prod = (LO_SHIFT+LEN_W)'({length_min, 1'b0}) * (LO_SHIFT+LEN_W)'(LO_RECIP);

  // divider result plus margin, saturated to the timer width
  assign q_sum = SUM_W'(div_quot) + SUM_W'(timeout_margin);
  assign q_sat = (q_sum > T_MAX_SUM) ? {TIME_BITS{1'b1}} : q_sum[TIME_BITS-1:0];

  assign ic_inc = (interval_count == {TIME_BITS{1'b1}}) ? interval_count
                                                        : interval_count + 1'b1;
  assign phase_cur = phase_on ? phase_value : '0;

  // operands for the divider, registered inside it
  assign mul_left  = MUL_W'(interval_count) * MUL_W'(p_eff - pulse_index);
  assign mul_to    = MUL_W'(interval_count) * MUL_W'({1'b0, pulse_index} + 6'd1);
  assign mul_scale = DIV_W'(phase_value) * DIV_W'(pending);

  // start of tick: soft reset on a reset edge or on the first clock edge
  assign front_sr = in_rst || (in_clk && !running_flag);
  assign pi_base  = front_sr ? IDX_NONE : pulse_index;
  assign pi_adv   = ((pi_base == IDX_NONE) || (({1'b0, pi_base} + 6'd1) >= {1'b0, p_eff}))
                    ? '0 : pi_base + 1'b1;
  assign mp_norm   = clamp_len(SUM_W'(master_period), LEN_W'(length_min), LEN_W'(length_max));
  assign pend_norm = clamp_len(SUM_W'(pending), LEN_W'(length_min), LEN_W'(length_max));

  assign stop = running_flag && (ic_inc > timeout_count);

  // end of tick: counter start and advance
  assign po_t = phase_on || running_flag;
  assign pv_t = phase_on ? phase_value : '0;
  assign pv1  = {1'b0, pv_t} + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      running_flag   <= 1'b0;
      pulse_index    <= IDX_NONE;
      interval_count <= '0;
      timeout_count  <= TC_INIT;
      master_period  <= LEN_W'(DEF_LEN_RST);
      phase_value    <= '0;
      phase_on       <= 1'b0;
    end else begin
      state          <= state_next;
      running_flag   <= running_flag_next;
      pulse_index    <= pulse_index_next;
      interval_count <= interval_count_next;
      timeout_count  <= timeout_count_next;
      master_period  <= master_period_next;
      phase_value    <= phase_value_next;
      phase_on       <= phase_on_next;
    end
  end

  always_ff @(posedge clk) begin
    in_clk  <= in_clk_next;
    in_rst  <= in_rst_next;
    tb      <= tb_next;
    lo_wide <= lo_wide_next;
    pending <= pending_next;
  end

  // sequencer
  always_comb begin
    state_next          = state;
    running_flag_next   = running_flag;
    pulse_index_next    = pulse_index;
    interval_count_next = interval_count;
    timeout_count_next  = timeout_count;
    master_period_next  = master_period;
    phase_value_next    = phase_value;
    phase_on_next       = phase_on;
    in_clk_next         = in_clk;
    in_rst_next         = in_rst;
    tb_next             = tb;
    lo_wide_next        = lo_wide;
    pending_next        = pending;
    load_out            = 1'b0;
    div_req             = '0;

    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          in_clk_next   = s_tdata[0];
          in_rst_next   = s_tdata[1];
          // timeout base: length_max / pulses
          div_req.start = 1'b1;
          div_req.nbits = CNT_W'(CFG_W);
          div_req.num   = DIV_W'(length_max) << (DIV_W - CFG_W);
          div_req.den   = LEN_W'(p_eff);
          state_next    = ST_TB;
        end
      end

      ST_TB: begin
        if (div_done) begin
          tb_next    = q_sat;
          state_next = ST_FRONT;
        end
      end

      ST_FRONT: begin
        pending_next = master_period;
        if (front_sr) begin
          phase_on_next       = 1'b0;
          phase_value_next    = '0;
          pulse_index_next    = IDX_NONE;
          interval_count_next = '0;
          timeout_count_next  = tb;
          master_period_next  = mp_norm;
          pending_next        = mp_norm;
        end
        if (in_clk) begin
          running_flag_next = 1'b1;
          pulse_index_next  = pi_adv;
          if (pi_adv == '0) begin
            interval_count_next = '0;
            state_next          = ST_RUN;
          end else begin
            state_next = ST_LO;
          end
        end else begin
          state_next = ST_RUN;
        end
      end

      ST_LO: begin
        // wide range lower bound, length_min*2/3
        lo_wide_next  = lo_prod[LO_SHIFT +: LEN_W];
        // time left in the period: interval*(P-idx)/idx
        div_req.start = 1'b1;
        div_req.nbits = CNT_W'(MUL_W);
        div_req.num   = DIV_W'(mul_left) << ALIGN;
        div_req.den   = LEN_W'(pulse_index);
        state_next    = ST_LEFT;
      end

      ST_LEFT: begin
        if (div_done) begin
          pending_next  = clamp_len(SUM_W'(phase_cur) + SUM_W'(div_quot),
                                    lo_wide, hi_wide);
          // next edge expected at interval*(idx+1)/idx
          div_req.start = 1'b1;
          div_req.nbits = CNT_W'(MUL_W);
          div_req.num   = DIV_W'(mul_to) << ALIGN;
          div_req.den   = LEN_W'(pulse_index);
          state_next    = ST_TO;
        end
      end

      ST_TO: begin
        if (div_done) begin
          timeout_count_next = q_sat;
          state_next         = ST_RUN;
        end
      end

      ST_RUN: begin
        if (running_flag) begin
          interval_count_next = ic_inc;
        end
        if (stop) begin
          // timeout: stop and soft reset, pending length clamped to length_min..length_max
          running_flag_next   = 1'b0;
          phase_on_next       = 1'b0;
          phase_value_next    = '0;
          pulse_index_next    = IDX_NONE;
          interval_count_next = '0;
          timeout_count_next  = tb;
          master_period_next  = pend_norm;
          state_next          = ST_TAIL;
        end else if (pending != master_period) begin
          if (phase_on) begin
            // rescale the phase: phase*pending/master_period
            div_req.start = 1'b1;
            div_req.nbits = CNT_W'(DIV_W);
            div_req.num   = mul_scale;
            div_req.den   = master_period;
            state_next    = ST_SCALE;
          end else begin
            master_period_next = pending;
            state_next         = ST_TAIL;
          end
        end else begin
          state_next = ST_TAIL;
        end
      end

      ST_SCALE: begin
        if (div_done) begin
          phase_value_next   = div_quot[LEN_W-1:0];
          master_period_next = pending;
          state_next         = ST_TAIL;
        end
      end

      ST_TAIL: begin
        if (po_t) begin
          if (pv1 >= {1'b0, master_period}) begin
            phase_on_next    = 1'b0;
            phase_value_next = '0;
          end else begin
            phase_on_next    = 1'b1;
            phase_value_next = pv1[LEN_W-1:0];
          end
        end
        state_next = ST_DONE;
      end

      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // output register, frees up on the receiver's transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {{(OUT_DATA_W - 2 * LEN_W - 2){1'b0}}, phase_on, phase_cur,
                  master_period, running_flag};
    end
  end

  // between ticks a stopped counter sits at zero
  a_phase_zero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && !phase_on) |-> (phase_value == '0))
    else $error("stopped phase counter is not zero");

  // between ticks a running counter stays inside the period
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && phase_on) |-> (phase_value < master_period))
    else $error("phase counter past period length");

  // divider results only show up while the sequencer waits for them
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_TB || state == ST_LEFT ||
                  state == ST_TO || state == ST_SCALE))
    else $error("divider finished outside a wait state");

  // a finished result waits while the output register is still full
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && m_tvalid && !m_tready) |=> (state == ST_DONE))
    else $error("result overwrote a pending output");

  // pulse index is either unset or below the largest pulse count
  a_index: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (pulse_index == IDX_NONE || pulse_index < P_MAX))
    else $error("pulse index out of range");

endmodule
